// File: hw/rtl/ompm_pkg.sv
// ---------------------------------------------------------------------------
// ompm_pkg: shared definitions for the one-mismatch pattern matcher
// Sizes, item kind codes and the control word that drives the cell row.
// ---------------------------------------------------------------------------
package ompm_pkg;

   // Sizes
   localparam int PATTERN_MAX = 256;
   localparam int TEXT_MAX    = 1048576;
   localparam int LEN_W       = $clog2(PATTERN_MAX + 1);
   localparam int POS_W       = $clog2(TEXT_MAX);
   localparam int SYM_W       = 8;
   localparam int KIND_W      = 2;
   localparam int CNT_W       = 2;

   // Last text index that is still scanned plus one: the position stops here
   localparam logic [POS_W-1:0] POS_LAST = POS_W'(TEXT_MAX - 1);

   // Saturated window mismatch count
   localparam logic [CNT_W-1:0] CNT_SAT = CNT_W'(2);

   // Item kinds
   localparam logic [KIND_W-1:0] KIND_START   = KIND_W'(0);
   localparam logic [KIND_W-1:0] KIND_PATTERN = KIND_W'(1);
   localparam logic [KIND_W-1:0] KIND_TEXT    = KIND_W'(2);

   // Control word broadcast to every cell
   typedef struct packed {
      logic             shift;   // text beat processed: advance the counters
      logic [SYM_W-1:0] symbol;  // byte of the current beat
   } cell_ctrl_type;

endpackage

// File: hw/rtl/ompm_if.sv
// ---------------------------------------------------------------------------
// ompm_if: valid/ready channels of the one-mismatch pattern matcher
// Request channel carries job, pattern and text items; response channel
// carries match reports.
// ---------------------------------------------------------------------------
interface ompm_req_if;
   logic                        valid;
   logic                        ready;
   logic [ompm_pkg::KIND_W-1:0] kind;
   logic [ompm_pkg::SYM_W-1:0]  symbol;

   modport source (output valid, output kind, output symbol, input ready);
   modport sink   (input valid, input kind, input symbol, output ready);
endinterface

interface ompm_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [ompm_pkg::POS_W-1:0] match_start;
   logic                       mismatch_count;

   modport source (output valid, output match_start, output mismatch_count, input ready);
   modport sink   (input valid, input match_start, input mismatch_count, output ready);
endinterface

// File: hw/rtl/ompm_cell.sv
// ---------------------------------------------------------------------------
// ompm_cell: one pattern position of the matcher row
// Holds one pattern byte and the mismatch count of the window whose latest
// compare fell on this position; hands the count to the next cell.
// ---------------------------------------------------------------------------
module ompm_cell (
   input  logic                           clock,
   input  ompm_pkg::cell_ctrl_type        ctrl,
   input  logic                           load,
   input  logic [ompm_pkg::CNT_W-1:0]     cnt_prev,
   output logic [ompm_pkg::CNT_W-1:0]     cnt_calc,
   output logic [ompm_pkg::CNT_W-1:0]     cnt_out
);

   logic [ompm_pkg::SYM_W-1:0] pat_ff;
   logic [ompm_pkg::SYM_W-1:0] pat_in;
   logic [ompm_pkg::CNT_W-1:0] cnt_ff;
   logic [ompm_pkg::CNT_W-1:0] cnt_in;
   logic [ompm_pkg::CNT_W:0]   sum;

   // Compare this beat's byte and add to the count from the left neighbor
   always_comb begin
      sum = {1'b0, cnt_prev} + {{ompm_pkg::CNT_W{1'b0}}, (pat_ff != ctrl.symbol)};
      if (sum >= {1'b0, ompm_pkg::CNT_SAT}) begin
         cnt_calc = ompm_pkg::CNT_SAT;
      end else begin
         cnt_calc = sum[ompm_pkg::CNT_W-1:0];
      end
   end

   // Hold the pattern byte until this position is written again
   assign pat_in = load ? ctrl.symbol : pat_ff;
   // Advance the count only on processed text beats
   assign cnt_in = ctrl.shift ? cnt_calc : cnt_ff;

   always_ff @(posedge clock) begin
      pat_ff <= pat_in;
      cnt_ff <= cnt_in;
   end

   assign cnt_out = cnt_ff;

endmodule

// File: hw/rtl/one_mismatch_pattern_matcher.sv
// ---------------------------------------------------------------------------
// one_mismatch_pattern_matcher: streaming Hamming-distance-one matcher
// Loads a pattern byte by byte, then reports every text window that differs
// from it in at most one byte.
// ---------------------------------------------------------------------------
// Takes one item per clock while ready. A row of PATTERN_MAX cells compares
// each text byte against every pattern byte at once; each cell hands its
// window's mismatch count to the next cell, so the window that ends on the
// current byte is read at the cell of the last pattern byte. A report goes
// into the response register and appears the cycle after its text beat; req
// ready falls only while that register holds a report not yet taken. A start
// beat clears the pattern and position; a pattern beat appends a byte (bytes
// beyond PATTERN_MAX are dropped) and restarts the text scan. The position
// stops at TEXT_MAX-1, after which text beats give no report.
// ---------------------------------------------------------------------------
module one_mismatch_pattern_matcher (
   input  logic        clock,
   input  logic        reset,
   ompm_req_if.sink    req_chan,
   ompm_rsp_if.source  rsp_chan
);

   localparam int NCELL = ompm_pkg::PATTERN_MAX;
   localparam int LEN_W = ompm_pkg::LEN_W;
   localparam int POS_W = ompm_pkg::POS_W;
   localparam int CNT_W = ompm_pkg::CNT_W;

   logic [LEN_W-1:0] len_ff, len_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             out_valid_ff, out_valid_in;
   logic [POS_W-1:0] out_start_ff, out_start_in;
   logic             out_mis_ff, out_mis_in;

   logic                    req_fire;
   logic                    is_start, is_pattern, is_text;
   logic                    text_live;
   logic                    emit;
   logic [POS_W-1:0]        last_off;
   logic [CNT_W-1:0]        hit_cnt;
   ompm_pkg::cell_ctrl_type ctrl;

   logic [NCELL-1:0]        load_vec;
   logic [NCELL-1:0]        last_vec;
   logic [CNT_W-1:0]        cnt_chain [NCELL+1];
   logic [CNT_W-1:0]        cnt_calc  [NCELL];

   // Decode the beat
   assign req_chan.ready = !out_valid_ff || rsp_chan.ready;
   assign req_fire   = req_chan.valid && req_chan.ready;
   assign is_start   = req_fire && (req_chan.kind == ompm_pkg::KIND_START);
   assign is_pattern = req_fire && (req_chan.kind == ompm_pkg::KIND_PATTERN);
   assign is_text    = req_fire && (req_chan.kind == ompm_pkg::KIND_TEXT);
   assign text_live  = is_text && (pos_ff != ompm_pkg::POS_LAST);

   assign ctrl.shift  = text_live;
   assign ctrl.symbol = req_chan.symbol;

   // Select the cell that writes the next pattern byte and the last cell
   always_comb begin
      for (int k = 0; k < NCELL; k++) begin
         load_vec[k] = is_pattern && (len_ff == LEN_W'(k));
         last_vec[k] = (len_ff == LEN_W'(k + 1));
      end
   end

   // Cell row; the first cell starts a fresh window
   assign cnt_chain[0] = '0;

   for (genvar k = 0; k < NCELL; k++) begin : g_cell
      ompm_cell u_cell (
         .clock    (clock),
         .ctrl     (ctrl),
         .load     (load_vec[k]),
         .cnt_prev (cnt_chain[k]),
         .cnt_calc (cnt_calc[k]),
         .cnt_out  (cnt_chain[k+1])
      );
   end

   // Pick the count of the window ending on this byte
   always_comb begin
      hit_cnt = '0;
      for (int k = 0; k < NCELL; k++) begin
         hit_cnt = hit_cnt | (cnt_calc[k] & {CNT_W{last_vec[k]}});
      end
   end

   // Report windows with at most one mismatch from the first full window on
   assign last_off = POS_W'(len_ff) - POS_W'(1);
   assign emit = text_live && (len_ff != '0) && (pos_ff >= last_off) &&
                 (hit_cnt < ompm_pkg::CNT_SAT);

   // Advance length and position
   always_comb begin
      len_in = len_ff;
      pos_in = pos_ff;
      if (is_start) begin
         len_in = '0;
         pos_in = '0;
      end else if (is_pattern) begin
         if (len_ff != LEN_W'(NCELL)) begin
            len_in = len_ff + LEN_W'(1);
         end
         pos_in = '0;
      end else if (text_live) begin
         pos_in = pos_ff + POS_W'(1);
      end
   end

   // Load or drain the response register
   always_comb begin
      out_valid_in = out_valid_ff;
      out_start_in = out_start_ff;
      out_mis_in   = out_mis_ff;
      if (req_fire) begin
         out_valid_in = emit;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
      if (emit) begin
         out_start_in = pos_ff - last_off;
         out_mis_in   = hit_cnt[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         pos_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         pos_ff       <= pos_in;
         out_valid_ff <= out_valid_in;
      end
      out_start_ff <= out_start_in;
      out_mis_ff   <= out_mis_in;
   end

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.match_start    = out_start_ff;
   assign rsp_chan.mismatch_count = out_mis_ff;

endmodule
